FILE: sv/pas_pkg.sv
// Shared types, widths and helper functions of the paged array slot translator.
`default_nettype none

package pas_pkg;

  localparam int unsigned IdxW     = 24;
  localparam int unsigned PageW    = 16;
  localparam int unsigned OffW     = 8;
  localparam int unsigned SlotOutW = 6;
  localparam int unsigned CntW     = 32;
  localparam int unsigned SeedW    = 16;
  localparam int unsigned MaxSlotW = 6;

  localparam int unsigned DivW     = 13;
  localparam int unsigned RecipW   = IdxW + 1;
  localparam int unsigned ProdW    = 2 * RecipW;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned OutUserW = 2;

  typedef struct packed {
    logic                rd_en;
    logic [MaxSlotW-1:0] rd_idx;
    logic                wr_en;
    logic [MaxSlotW-1:0] wr_idx;
    logic [PageW-1:0]    wr_page;
  } tbl_req_t;

  typedef struct packed {
    logic                rd_vld;
    logic [MaxSlotW-1:0] rd_idx;
    logic                valid;
    logic [PageW-1:0]    page;
  } tbl_rsp_t;

  function automatic logic [SeedW-1:0] lfsr_next(input logic [SeedW-1:0] v);
    logic b;
    b = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {b, v[SeedW-1:1]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/pas_div.sv
// Shared multiplier unit that divides by one of two constant divisors through a reciprocal.
`default_nettype none

module pas_div
  import pas_pkg::*;
#(
  parameter int unsigned WORDS_PER_PAGE = 256,
  parameter int unsigned SLOTS          = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              sel_slots_i,
  input  wire logic [IdxW-1:0]   dividend_i,
  output logic                   done_o,
  output logic [IdxW-1:0]        quot_o,
  output logic [DivW-1:0]        rem_o
);

  localparam int unsigned WppShift   = IdxW + $clog2(WORDS_PER_PAGE);
  localparam int unsigned SlotsShift = IdxW + $clog2(SLOTS);
  localparam logic [63:0] WppRecip64 =
      ((64'd1 << WppShift) + 64'(WORDS_PER_PAGE) - 64'd1) / 64'(WORDS_PER_PAGE);
  localparam logic [63:0] SlotsRecip64 =
      ((64'd1 << SlotsShift) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [RecipW-1:0] WppRecip   = RecipW'(WppRecip64);
  localparam logic [RecipW-1:0] SlotsRecip = RecipW'(SlotsRecip64);
  localparam logic [RecipW-1:0] WppDiv     = RecipW'(WORDS_PER_PAGE);
  localparam logic [RecipW-1:0] SlotsDiv   = RecipW'(SLOTS);

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhBack = 3'b010,
    PhRem  = 3'b100
  } phase_e;

  phase_e             phase_q, phase_d;
  logic               done_q, done_d;
  logic               sel_q, sel_d;
  logic [IdxW-1:0]    dvd_q, dvd_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [IdxW-1:0]    quot_q, quot_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [IdxW-1:0]    quot_est;
  logic [RecipW-1:0]  mul_a;
  logic [RecipW-1:0]  mul_b;
  logic [ProdW-1:0]   mul_p;

  assign quot_est = sel_q ? IdxW'(prod_q >> SlotsShift) : IdxW'(prod_q >> WppShift);
  assign mul_a    = start_i ? RecipW'(dividend_i) : RecipW'(quot_est);
  assign mul_b    = start_i ? (sel_slots_i ? SlotsRecip : WppRecip)
                            : (sel_q ? SlotsDiv : WppDiv);
  assign mul_p    = ProdW'(mul_a) * ProdW'(mul_b);

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    sel_d   = sel_q;
    dvd_d   = dvd_q;
    prod_d  = prod_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    if (start_i) begin
      sel_d   = sel_slots_i;
      dvd_d   = dividend_i;
      prod_d  = mul_p;
      phase_d = PhBack;
    end else begin
      case (phase_q)
        PhIdle: begin
          phase_d = PhIdle;
        end
        PhBack: begin
          quot_d  = quot_est;
          prod_d  = mul_p;
          phase_d = PhRem;
        end
        PhRem: begin
          rem_d   = DivW'(dvd_q) - DivW'(prod_q);
          done_d  = 1'b1;
          phase_d = PhIdle;
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    dvd_q  <= dvd_d;
    prod_q <= prod_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: sv/pas_table.sv
// Slot table holding the resident page of each slot with a registered read port.
`default_nettype none

module pas_table
  import pas_pkg::*;
#(
  parameter int unsigned SLOTS = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tbl_req_t req_i,
  output tbl_rsp_t      rsp_o
);

  localparam int unsigned SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0]    valid_q;
  logic [PageW-1:0]    page_mem [SLOTS];
  logic                rd_vld_q;
  logic                rd_valid_q;
  logic [MaxSlotW-1:0] rd_idx_q;
  logic [PageW-1:0]    rd_page_q;
  logic [SlotIdxW-1:0] ridx;
  logic [SlotIdxW-1:0] widx;

  assign ridx = req_i.rd_idx[SlotIdxW-1:0];
  assign widx = req_i.wr_idx[SlotIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= req_i.rd_en;
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[ridx];
      end
      if (req_i.wr_en) begin
        valid_q[widx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      page_mem[widx] <= req_i.wr_page;
    end
    if (req_i.rd_en) begin
      rd_page_q <= page_mem[ridx];
      rd_idx_q  <= req_i.rd_idx;
    end
  end

  assign rsp_o.rd_vld = rd_vld_q;
  assign rsp_o.rd_idx = rd_idx_q;
  assign rsp_o.valid  = rd_valid_q;
  assign rsp_o.page   = rd_page_q;

endmodule

`default_nettype wire

FILE: sv/paged_array_slot_translator.sv
// Top level of the paged array slot translator with its sequencer and result register.
//
// An element index enters on the s_axis channel and is translated into a page number,
// a word offset and the table slot that now holds the page. One shared multiplier splits
// the index by WORDS_PER_PAGE through a reciprocal product and a back multiplication,
// then the slot table is scanned one slot per cycle. On a miss with no free slot the
// victim LFSR steps once and the same unit reduces it modulo SLOTS to pick the slot to
// evict, whose old page is read back and reported.
// One result transaction leaves on the m_axis channel for every input transaction.
// A hit or a fill of a free slot passes through the division, the per-slot scan, the
// decision and the commit step before m_axis_tvalid rises; an eviction adds a second
// division by SLOTS and a read of the evicted slot before the commit step.
// s_axis_tready is high only while no item is in progress.
// A finished result sits in the output register; while the receiver stalls the block
// still accepts and works on the next item and holds it until the register frees up.
// Reset empties the table, clears both counters, loads the LFSR with 1 and drops
// m_axis_tvalid. A write on the cfg channel loads the LFSR with the seed, or with 1 when
// the seed is zero; it is always accepted and is expected only while the block is idle.
`default_nettype none

module paged_array_slot_translator
  import pas_pkg::*;
#(
  parameter int unsigned SLOTS          = 4,
  parameter int unsigned WORDS_PER_PAGE = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // element_index[23:0]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // slot[5:0], page_number[21:6], word_offset[29:22], evicted_page[45:30],
  // fault_total[77:46], hit_total[109:78], zero fill[111:110]
  output logic [OutDataW-1:0]      m_axis_tdata,
  // hit[0], evict[1]
  output logic [OutUserW-1:0]      m_axis_tuser,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [SeedW-1:0]    cfg_data_i
);

  localparam int unsigned ScanW = $clog2(SLOTS + 1);
  localparam logic [MaxSlotW-1:0] LastSlot = MaxSlotW'(SLOTS - 1);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StDiv    = 7'b0000010,
    StScan   = 7'b0000100,
    StDecide = 7'b0001000,
    StMod    = 7'b0010000,
    StEvRd   = 7'b0100000,
    StCommit = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [ScanW-1:0]    scan_q, scan_d;
  logic                hit_q, hit_d;
  logic                free_q, free_d;
  logic                evict_q, evict_d;
  logic [MaxSlotW-1:0] hit_slot_q, hit_slot_d;
  logic [MaxSlotW-1:0] free_slot_q, free_slot_d;
  logic [MaxSlotW-1:0] slot_q, slot_d;
  logic [PageW-1:0]    page_q, page_d;
  logic [OffW-1:0]     off_q, off_d;
  logic [PageW-1:0]    old_page_q, old_page_d;
  logic [SeedW-1:0]    lfsr_q, lfsr_d;
  logic [CntW-1:0]     fault_cnt_q, fault_cnt_d;
  logic [CntW-1:0]     hit_cnt_q, hit_cnt_d;
  logic                out_vld_q, out_vld_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [OutUserW-1:0] out_user_q, out_user_d;

  logic                div_start;
  logic [IdxW-1:0]     div_dividend;
  logic                div_sel_slots;
  logic                div_done;
  logic [IdxW-1:0]     div_quot;
  logic [DivW-1:0]     div_rem;
  tbl_req_t            tbl_req;
  tbl_rsp_t            tbl_rsp;
  logic                out_free;

  pas_div #(
    .WORDS_PER_PAGE (WORDS_PER_PAGE),
    .SLOTS          (SLOTS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .sel_slots_i (div_sel_slots),
    .dividend_i  (div_dividend),
    .done_o      (div_done),
    .quot_o      (div_quot),
    .rem_o       (div_rem)
  );

  pas_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    scan_d        = scan_q;
    hit_d         = hit_q;
    free_d        = free_q;
    evict_d       = evict_q;
    hit_slot_d    = hit_slot_q;
    free_slot_d   = free_slot_q;
    slot_d        = slot_q;
    page_d        = page_q;
    off_d         = off_q;
    old_page_d    = old_page_q;
    lfsr_d        = lfsr_q;
    fault_cnt_d   = fault_cnt_q;
    hit_cnt_d     = hit_cnt_q;
    out_vld_d     = out_vld_q;
    out_data_d    = out_data_q;
    out_user_d    = out_user_q;
    div_start     = 1'b0;
    div_dividend  = s_axis_tdata[IdxW-1:0];
    div_sel_slots = 1'b0;
    tbl_req       = '0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          div_start  = 1'b1;
          hit_d      = 1'b0;
          free_d     = 1'b0;
          evict_d    = 1'b0;
          old_page_d = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          page_d  = div_quot[PageW-1:0];
          off_d   = div_rem[OffW-1:0];
          scan_d  = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (scan_q < ScanW'(SLOTS)) begin
          tbl_req.rd_en  = 1'b1;
          tbl_req.rd_idx = MaxSlotW'(scan_q);
          scan_d         = scan_q + ScanW'(1);
        end
        if (tbl_rsp.rd_vld) begin
          if (tbl_rsp.valid && tbl_rsp.page == page_q && !hit_q) begin
            hit_d      = 1'b1;
            hit_slot_d = tbl_rsp.rd_idx;
          end
          if (!tbl_rsp.valid && !free_q) begin
            free_d      = 1'b1;
            free_slot_d = tbl_rsp.rd_idx;
          end
          if (tbl_rsp.rd_idx == LastSlot) begin
            state_d = StDecide;
          end
        end
      end
      StDecide: begin
        if (hit_q) begin
          slot_d  = hit_slot_q;
          state_d = StCommit;
        end else if (free_q) begin
          slot_d  = free_slot_q;
          state_d = StCommit;
        end else begin
          lfsr_d        = lfsr_next(lfsr_q);
          div_start     = 1'b1;
          div_dividend  = IdxW'(lfsr_next(lfsr_q));
          div_sel_slots = 1'b1;
          state_d       = StMod;
        end
      end
      StMod: begin
        if (div_done) begin
          slot_d         = div_rem[MaxSlotW-1:0];
          tbl_req.rd_en  = 1'b1;
          tbl_req.rd_idx = div_rem[MaxSlotW-1:0];
          state_d        = StEvRd;
        end
      end
      StEvRd: begin
        if (tbl_rsp.rd_vld) begin
          old_page_d = tbl_rsp.page;
          evict_d    = 1'b1;
          state_d    = StCommit;
        end
      end
      StCommit: begin
        if (out_free) begin
          if (hit_q) begin
            hit_cnt_d = hit_cnt_q + CntW'(1);
          end else begin
            fault_cnt_d     = fault_cnt_q + CntW'(1);
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_idx  = slot_q;
            tbl_req.wr_page = page_q;
          end
          out_vld_d  = 1'b1;
          out_data_d = {2'b00, hit_cnt_d, fault_cnt_d, old_page_q, off_q, page_q,
                        SlotOutW'(slot_q)};
          out_user_d = {evict_q, hit_q};
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_valid_i) begin
      lfsr_d = (cfg_data_i == '0) ? SeedW'(1) : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      evict_q     <= 1'b0;
      lfsr_q      <= SeedW'(1);
      fault_cnt_q <= '0;
      hit_cnt_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      evict_q     <= evict_d;
      lfsr_q      <= lfsr_d;
      fault_cnt_q <= fault_cnt_d;
      hit_cnt_q   <= hit_cnt_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
    slot_q      <= slot_d;
    page_q      <= page_d;
    off_q       <= off_d;
    old_page_q  <= old_page_d;
    out_data_q  <= out_data_d;
    out_user_q  <= out_user_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the paged array slot translator: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import pas_pkg::*;

  localparam int unsigned SlotCount   = 4;
  localparam int unsigned PageWords   = 256;
  localparam int unsigned CycleLimit  = 800000;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned PhaseItems  = 115;
  localparam int unsigned DrainCycles = 80;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic [15:0] page;
    logic [7:0]  offset;
    logic        evict;
    logic [15:0] evicted_page;
    logic [31:0] faults;
    logic [31:0] hits;
  } xlate_t;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            typed;
    xlate_t          want;
  } access_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SeedW-1:0]    cfg_data_i = '0;

  access_t     cur_access = '0;
  xlate_t      xlate_queue[$];
  access_t     dir_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned rx_mode = 0;
  int unsigned stall_left = 0;

  logic        page_valid[SlotCount];
  logic [15:0] page_tag[SlotCount];
  logic [15:0] victim_reg;
  logic [31:0] fault_tally;
  logic [31:0] hit_tally;

  paged_array_slot_translator #(
    .SLOTS          (SlotCount),
    .WORDS_PER_PAGE (PageWords)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] victim_step(input logic [15:0] v);
    return {v[0] ^ v[2] ^ v[3] ^ v[5], v[15:1]};
  endfunction

  function automatic xlate_t translate_access(input logic [IdxW-1:0] index);
    xlate_t      r;
    int          found;
    int          k;
    logic [15:0] pg;
    pg = 16'(index / PageWords);
    r = '0;
    r.page = pg;
    r.offset = 8'(index % PageWords);
    found = -1;
    for (k = 0; k < SlotCount; k++) begin
      if (found < 0 && page_valid[k] && page_tag[k] == pg) found = k;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      hit_tally = hit_tally + 1;
    end else begin
      for (k = 0; k < SlotCount; k++) begin
        if (found < 0 && !page_valid[k]) found = k;
      end
      if (found < 0) begin
        victim_reg = victim_step(victim_reg);
        found = victim_reg % SlotCount;
        r.evict = 1'b1;
        r.evicted_page = page_tag[found];
      end
      page_valid[found] = 1'b1;
      page_tag[found] = pg;
      fault_tally = fault_tally + 1;
    end
    r.slot = 6'(found);
    r.faults = fault_tally;
    r.hits = hit_tally;
    return r;
  endfunction

  function automatic access_t pred_row(input logic [IdxW-1:0] index);
    access_t a;
    a = '0;
    a.index = index;
    return a;
  endfunction

  function automatic access_t typed_row(input logic [IdxW-1:0] index, input logic hit,
                                        input logic [5:0] slot, input logic [15:0] page,
                                        input logic [7:0] offset, input logic [31:0] faults,
                                        input logic [31:0] hits);
    access_t a;
    a = '0;
    a.index = index;
    a.typed = 1'b1;
    a.want.hit = hit;
    a.want.slot = slot;
    a.want.page = page;
    a.want.offset = offset;
    a.want.faults = faults;
    a.want.hits = hits;
    return a;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50) begin
      $display("MISMATCH at cycle %0d, %s: got %0h, want %0h", cycle_count, field, got, want);
    end
    mismatch_count++;
  endtask

  task automatic send_access(input access_t a);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= a.index;
    cur_access <= a;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (xlate_queue.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_mode != 0 && $urandom_range(0, (rx_mode == 1) ? 15 : 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, (rx_mode == 1) ? 10 : 90);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    xlate_t got;
    xlate_t want;
    if (!rst_ni) begin
      for (int k = 0; k < SlotCount; k++) begin
        page_valid[k] = 1'b0;
        page_tag[k] = '0;
      end
      victim_reg = 16'd1;
      fault_tally = '0;
      hit_tally = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        victim_reg = (cfg_data_i == '0) ? 16'd1 : cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = translate_access(cur_access.index);
        if (cur_access.typed) want = cur_access.want;
        xlate_queue.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit = m_axis_tuser[0];
        got.evict = m_axis_tuser[1];
        got.slot = m_axis_tdata[5:0];
        got.page = m_axis_tdata[21:6];
        got.offset = m_axis_tdata[29:22];
        got.evicted_page = m_axis_tdata[45:30];
        got.faults = m_axis_tdata[77:46];
        got.hits = m_axis_tdata[109:78];
        if (xlate_queue.size() == 0) begin
          report_mismatch("unexpected result, page", 32'(got.page), '0);
        end else begin
          want = xlate_queue.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
          if (got.slot !== want.slot) report_mismatch("slot", 32'(got.slot), 32'(want.slot));
          if (got.page !== want.page) begin
            report_mismatch("page_number", 32'(got.page), 32'(want.page));
          end
          if (got.offset !== want.offset) begin
            report_mismatch("word_offset", 32'(got.offset), 32'(want.offset));
          end
          if (got.evict !== want.evict) begin
            report_mismatch("evict", 32'(got.evict), 32'(want.evict));
          end
          if (got.evicted_page !== want.evicted_page) begin
            report_mismatch("evicted_page", 32'(got.evicted_page), 32'(want.evicted_page));
          end
          if (got.faults !== want.faults) report_mismatch("fault_total", got.faults, want.faults);
          if (got.hits !== want.hits) report_mismatch("hit_total", got.hits, want.hits);
          if (m_axis_tdata[OutDataW-1:110] !== '0) begin
            report_mismatch("zero fill", 32'(m_axis_tdata[OutDataW-1:110]), '0);
          end
        end
      end
    end
  end

  initial begin
    logic [15:0]     seed;
    logic [15:0]     pool[8];
    int unsigned     pool_size;
    logic [IdxW-1:0] index;

    // After reset: fill all four slots, hit on the page extremes, then force evictions.
    dir_rows.push_back(typed_row(24'h000000, 1'b0, 6'd0, 16'h0000, 8'h00, 32'd1, 32'd0));
    dir_rows.push_back(typed_row(24'hFFFFFF, 1'b0, 6'd1, 16'hFFFF, 8'hFF, 32'd2, 32'd0));
    dir_rows.push_back(typed_row(24'h0000FF, 1'b1, 6'd0, 16'h0000, 8'hFF, 32'd2, 32'd1));
    dir_rows.push_back(typed_row(24'hFFFF00, 1'b1, 6'd1, 16'hFFFF, 8'h00, 32'd2, 32'd2));
    dir_rows.push_back(typed_row(24'h000100, 1'b0, 6'd2, 16'h0001, 8'h00, 32'd3, 32'd2));
    dir_rows.push_back(typed_row(24'h7F8080, 1'b0, 6'd3, 16'h7F80, 8'h80, 32'd4, 32'd2));
    dir_rows.push_back(pred_row(24'h800000));
    dir_rows.push_back(pred_row(24'h555555));
    dir_rows.push_back(pred_row(24'hAAAAAA));
    dir_rows.push_back(pred_row(24'h000001));
    dir_rows.push_back(pred_row(24'h7F80FF));
    dir_rows.push_back(pred_row(24'hFFFFFE));
    dir_rows.push_back(pred_row(24'h0001AB));
    dir_rows.push_back(pred_row(24'h800001));
    dir_rows.push_back(pred_row(24'h123456));
    dir_rows.push_back(pred_row(24'h555500));
    dir_rows.push_back(pred_row(24'hAAAA55));
    dir_rows.push_back(pred_row(24'h000000));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    rx_mode = 1;
    foreach (dir_rows[i]) send_access(dir_rows[i]);
    wait_idle();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: seed = 16'h0000;
        1: seed = 16'hFFFF;
        2: seed = 16'h0001;
        3: seed = 16'h8000;
        default: seed = 16'($urandom_range(1, 65535));
      endcase
      cfg_valid_i <= 1'b1;
      cfg_data_i <= seed;
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);

      rx_mode = phase % 3;
      pool_size = $urandom_range(3, 8);
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 3) == 0) pool[k] = k[0] ? 16'hFFFF : 16'h0000;
        else pool[k] = 16'($urandom);
      end

      repeat (PhaseItems) begin
        if ($urandom_range(0, 4) == 0) begin
          index = IdxW'($urandom);
        end else begin
          index = IdxW'(pool[$urandom_range(0, pool_size - 1)] * PageWords
                        + $urandom_range(0, PageWords - 1));
        end
        send_access(pred_row(index));
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
